// ===== rtl/assert_macros.svh =====
// Assertion macros for the climate relay RTL.
// Concurrent checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CRHC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");
`define CRHC_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m: assertion failed");
`else
`define CRHC_ASSERT(lbl, clk, rst, prop)
`define CRHC_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// ===== rtl/crhc_pkg.sv =====
// Shared types and constants for the climate relay hysteresis controller.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package crhc_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_AUTO_ENABLE = 3'd0,
    REG_TEMP_SP     = 3'd1,
    REG_HUM_SP      = 3'd2,
    REG_CO2_SP      = 3'd3,
    REG_MANUAL      = 3'd4
  } crhc_reg_t;

  // Band edges in tenths of a unit, CO2 in ppm.
  localparam logic signed [12:0] TEMP_BAND = 13'sd30;
  localparam logic signed [12:0] TEMP_NEAR = 13'sd5;
  localparam logic signed [12:0] HUM_BAND  = 13'sd50;
  localparam logic [16:0]        CO2_BAND  = 17'd500;

  typedef struct packed {
    logic t_high;
    logic t_low;
    logic t_far;
    logic t_near;
    logic h_dry;
    logic h_wetok;
    logic h_wet;
    logic h_dryok;
    logic c_high;
    logic c_ok;
  } crhc_flags_t;

  typedef struct packed {
    logic temp_zero;
    logic hum_zero;
    logic co2_zero;
  } crhc_zero_t;

  typedef struct packed {
    logic valve;
    logic fan;
    logic pump;
  } crhc_relays_t;

endpackage
`default_nettype wire

// ===== rtl/crhc_band.sv =====
// Band comparators: turns one sample and the setpoints into hysteresis flags.
// Depends on crhc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module crhc_band
  import crhc_pkg::*;
(
  input  wire logic        [15:0] co2_ppm,
  input  wire logic signed [10:0] temp_tenths,
  input  wire logic        [9:0]  humidity_tenths,
  input  wire logic        [6:0]  temp_setpoint,
  input  wire logic        [6:0]  humidity_setpoint,
  input  wire logic        [15:0] co2_setpoint,
  output crhc_flags_t             flags
);

  logic        [10:0] ts10;
  logic        [10:0] hs10;
  logic signed [12:0] t_s;
  logic signed [12:0] ts_s;
  logic signed [12:0] h_s;
  logic signed [12:0] hs_s;
  logic signed [12:0] diff;
  logic signed [12:0] adiff;
  logic        [16:0] co2_hi_edge;

  // Setpoints in tenths: x*10 = x*8 + x*2.
  assign ts10 = {1'b0, temp_setpoint, 3'b000} + {3'b000, temp_setpoint, 1'b0};
  assign hs10 = {1'b0, humidity_setpoint, 3'b000} + {3'b000, humidity_setpoint, 1'b0};

  assign t_s   = {{2{temp_tenths[10]}}, temp_tenths};
  assign ts_s  = signed'({2'b00, ts10});
  assign h_s   = signed'({3'b000, humidity_tenths});
  assign hs_s  = signed'({2'b00, hs10});
  assign diff  = t_s - ts_s;
  assign adiff = diff[12] ? -diff : diff;

  assign co2_hi_edge = {1'b0, co2_setpoint} + CO2_BAND;

  always_comb begin
    flags.t_high  = t_s > (ts_s + TEMP_BAND);
    flags.t_low   = t_s <= ts_s;
    flags.t_far   = adiff > TEMP_BAND;
    flags.t_near  = adiff < TEMP_NEAR;
    flags.h_dry   = h_s < (hs_s - HUM_BAND);
    flags.h_wetok = h_s >= hs_s;
    flags.h_wet   = h_s > (hs_s + HUM_BAND);
    flags.h_dryok = h_s <= hs_s;
    flags.c_high  = {1'b0, co2_ppm} > co2_hi_edge;
    flags.c_ok    = co2_ppm <= co2_setpoint;
  end

endmodule
`default_nettype wire

// ===== rtl/crhc_relay.sv =====
// Relay update logic: picks the sub-mode and applies on/off hysteresis.
// Depends on crhc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module crhc_relay
  import crhc_pkg::*;
(
  input  wire logic         auto_enable,
  input  wire logic [2:0]   manual_relays,
  input  wire crhc_zero_t   zero,
  input  wire crhc_flags_t  flags,
  input  wire crhc_relays_t relays,
  output crhc_relays_t      relays_next
);

  typedef enum logic [2:0] {
    MODE_CO2,
    MODE_HUM,
    MODE_TEMP,
    MODE_TEMP_HUM,
    MODE_TEMP_CO2,
    MODE_HUM_CO2,
    MODE_ALL
  } mode_t;

  mode_t mode;

  // Priority follows the order in which the zero setpoints are examined.
  always_comb begin
    if (zero.temp_zero && zero.hum_zero) begin
      mode = MODE_CO2;
    end else if (zero.temp_zero && zero.co2_zero) begin
      mode = MODE_HUM;
    end else if (zero.hum_zero && zero.co2_zero) begin
      mode = MODE_TEMP;
    end else if (zero.co2_zero) begin
      mode = MODE_TEMP_HUM;
    end else if (zero.hum_zero) begin
      mode = MODE_TEMP_CO2;
    end else if (zero.temp_zero) begin
      mode = MODE_HUM_CO2;
    end else begin
      mode = MODE_ALL;
    end
  end

  function automatic logic hyst(input logic cur, input logic on, input logic off);
    hyst = on ? 1'b1 : (off ? 1'b0 : cur);
  endfunction

  always_comb begin
    relays_next = relays;
    if (!auto_enable) begin
      relays_next.pump  = manual_relays[0];
      relays_next.fan   = manual_relays[1];
      relays_next.valve = manual_relays[2];
    end else begin
      case (mode)
        MODE_CO2: begin
          relays_next.fan = hyst(relays.fan, flags.c_high, flags.c_ok);
        end
        MODE_HUM: begin
          relays_next.pump = hyst(relays.pump, flags.h_dry, flags.h_wetok);
          relays_next.fan  = hyst(relays.fan, flags.h_wet, flags.h_dryok);
        end
        MODE_TEMP: begin
          relays_next.pump  = hyst(relays.pump, flags.t_high, flags.t_low);
          relays_next.fan   = hyst(relays.fan, flags.t_far, flags.t_near);
          relays_next.valve = hyst(relays.valve, flags.t_high, flags.t_low);
        end
        MODE_TEMP_HUM: begin
          relays_next.pump  = hyst(relays.pump, flags.t_high || flags.h_dry,
                                   flags.t_low && flags.h_wetok);
          relays_next.fan   = hyst(relays.fan, flags.t_far || flags.h_wet,
                                   flags.t_near && flags.h_dryok);
          relays_next.valve = hyst(relays.valve, flags.t_high, flags.t_low);
        end
        MODE_TEMP_CO2: begin
          relays_next.pump  = hyst(relays.pump, flags.t_high, flags.t_low);
          relays_next.fan   = hyst(relays.fan, flags.t_far || flags.c_high,
                                   flags.t_near && flags.c_ok);
          relays_next.valve = hyst(relays.valve, flags.t_high, flags.t_low);
        end
        MODE_HUM_CO2: begin
          relays_next.pump = hyst(relays.pump, flags.h_dry, flags.h_wetok);
          relays_next.fan  = hyst(relays.fan, flags.h_wet || flags.c_high,
                                  flags.h_dryok && flags.c_ok);
        end
        MODE_ALL: begin
          relays_next.pump  = hyst(relays.pump, flags.t_high || flags.h_dry,
                                   flags.t_low && flags.h_wetok);
          relays_next.fan   = hyst(relays.fan,
                                   flags.t_far || flags.h_wet || flags.c_high,
                                   flags.t_near && flags.h_dryok && flags.c_ok);
          relays_next.valve = hyst(relays.valve, flags.t_high, flags.t_low);
        end
        default: begin
          relays_next = relays;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/climate_relay_hysteresis_controller.sv =====
// A result passes through the input register, then the relay state register,
// which is also the result register.
// Throughput: one item per cycle; ready stalls only when both registers are full
// and the result is not being taken.
// Reset (rst, synchronous, active high) clears all but the sample data registers; relays off.
// Depends on crhc_pkg, crhc_band, crhc_relay and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module climate_relay_hysteresis_controller
  import crhc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // [15:0] co2_ppm, [26:16] temp_tenths, [36:27] humidity_tenths, [39:37] unused
  input  wire logic [39:0]         s_tdata,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // [0] pump_on, [1] fan_on, [2] valve_on, [3] led_on, [7:4] zero
  output logic [7:0]               m_tdata
);

  logic        auto_enable;
  logic [6:0]  temp_setpoint;
  logic [6:0]  humidity_setpoint;
  logic [15:0] co2_setpoint;
  logic [3:0]  manual_switches;

  logic        in_valid;
  logic [15:0] co2_ppm;
  logic [10:0] temp_tenths;
  logic [9:0]  humidity_tenths;

  crhc_relays_t relays;
  crhc_relays_t relays_next;
  logic         led;
  logic         out_valid;

  logic         out_free;
  logic         load;
  crhc_flags_t  flags;
  crhc_zero_t   zero;

  assign out_free = !out_valid || m_tready;
  assign load     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      auto_enable       <= 1'b0;
      temp_setpoint     <= '0;
      humidity_setpoint <= '0;
      co2_setpoint      <= '0;
      manual_switches   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AUTO_ENABLE: auto_enable       <= cfg_data[0];
        REG_TEMP_SP:     temp_setpoint     <= cfg_data[6:0];
        REG_HUM_SP:      humidity_setpoint <= cfg_data[6:0];
        REG_CO2_SP:      co2_setpoint      <= cfg_data[15:0];
        REG_MANUAL:      manual_switches   <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      co2_ppm         <= s_tdata[15:0];
      temp_tenths     <= s_tdata[26:16];
      humidity_tenths <= s_tdata[36:27];
    end
  end

  assign zero.temp_zero = temp_setpoint == 7'd0;
  assign zero.hum_zero  = humidity_setpoint == 7'd0;
  assign zero.co2_zero  = co2_setpoint == 16'd0;

  crhc_band u_band (
    .co2_ppm           (co2_ppm),
    .temp_tenths       (signed'(temp_tenths)),
    .humidity_tenths   (humidity_tenths),
    .temp_setpoint     (temp_setpoint),
    .humidity_setpoint (humidity_setpoint),
    .co2_setpoint      (co2_setpoint),
    .flags             (flags)
  );

  crhc_relay u_relay (
    .auto_enable   (auto_enable),
    .manual_relays (manual_switches[2:0]),
    .zero          (zero),
    .flags         (flags),
    .relays        (relays),
    .relays_next   (relays_next)
  );

  // Relay state doubles as the result register; it moves only when an item lands.
  always_ff @(posedge clk) begin
    if (rst) begin
      relays    <= '0;
      led       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= in_valid;
      end
      if (load) begin
        relays <= relays_next;
        led    <= manual_switches[3];
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, led, relays.valve, relays.fan, relays.pump};

  `CRHC_ASSERT(a_manual_follow, clk, rst,
               (load && !auto_enable) |=> (relays.pump == $past(manual_switches[0]) &&
               relays.fan == $past(manual_switches[1]) &&
               relays.valve == $past(manual_switches[2])))
  `CRHC_ASSERT(a_hold_without_item, clk, rst, !load |=> $stable(relays) && $stable(led))
  `CRHC_ASSERT(a_co2_only_keeps, clk, rst,
               (load && auto_enable && zero.temp_zero && zero.hum_zero) |=>
               (relays.pump == $past(relays.pump) && relays.valve == $past(relays.valve)))

endmodule
`default_nettype wire

// ===== tb/tb_climate_relay_hysteresis_controller.sv =====
// Self-checking testbench for climate_relay_hysteresis_controller.
// Drives sensor samples and register writes, predicts relay states and checks
// every result. Depends on crhc_pkg and the controller RTL.
`timescale 1ns / 1ps
module tb_climate_relay_hysteresis_controller;
  import crhc_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int LONG_HOLD    = 80;
  localparam int PHASE_ITEMS  = 50;
  localparam int RAND_PHASES  = 16;
  localparam logic [CfgIdxW-1:0] REG_SPARE_LO = CfgIdxW'(REG_MANUAL + 1);
  localparam logic [CfgIdxW-1:0] REG_SPARE_HI = CfgIdxW'((1 << CfgIdxW) - 1);

  typedef struct packed {
    logic [9:0]  hum;
    logic [10:0] temp;
    logic [15:0] co2;
  } sample_t;

  typedef struct packed {
    logic led;
    logic valve;
    logic fan;
    logic pump;
  } relay_out_t;

  typedef enum int {
    MODE_CO2, MODE_HUM, MODE_TEMP, MODE_TEMP_HUM,
    MODE_TEMP_CO2, MODE_HUM_CO2, MODE_ALL, MODE_MANUAL
  } ctrl_mode_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [39:0]         s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [7:0]          m_tdata;

  climate_relay_hysteresis_controller uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Register copies and relay states as the controller should hold them.
  logic        cfg_auto = 1'b0;
  logic [6:0]  cfg_temp_sp = '0;
  logic [6:0]  cfg_hum_sp = '0;
  logic [15:0] cfg_co2_sp = '0;
  logic [3:0]  cfg_switches = '0;
  logic        pump_st = 1'b0;
  logic        fan_st = 1'b0;
  logic        valve_st = 1'b0;

  sample_t    pending_samples[$];
  relay_out_t expected_relays[$];

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_requests = 0;
  bit  offer_taken = 1'b0;
  int  errors = 0;
  int  samples_in = 0;
  int  results_out = 0;
  int  settings_used = 0;
  int  mode_hits[8];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic hyst(logic cur, bit on, bit off);
    return on ? 1'b1 : (off ? 1'b0 : cur);
  endfunction

  // Updates the relay states for one sample and returns the resulting outputs.
  function automatic relay_out_t next_relays(sample_t s);
    int t, h, c, ts, hs, cs, ad;
    bit t_high, t_low, t_far, t_near, h_dry, h_wetok, h_wet, h_dryok, c_high, c_ok;
    bit tz, hz, cz;
    ctrl_mode_t mode;
    relay_out_t r;
    t  = int'($signed(s.temp));
    h  = int'(s.hum);
    c  = int'(s.co2);
    ts = 10 * int'(cfg_temp_sp);
    hs = 10 * int'(cfg_hum_sp);
    cs = int'(cfg_co2_sp);
    ad = (t < ts) ? ts - t : t - ts;
    t_high = t > ts + 30;  t_low   = t <= ts;
    t_far  = ad > 30;      t_near  = ad < 5;
    h_dry  = h < hs - 50;  h_wetok = h >= hs;
    h_wet  = h > hs + 50;  h_dryok = h <= hs;
    c_high = c > cs + 500; c_ok    = c <= cs;
    tz = cfg_temp_sp == 0;
    hz = cfg_hum_sp == 0;
    cz = cfg_co2_sp == 0;

    if (!cfg_auto)     mode = MODE_MANUAL;
    else if (tz && hz) mode = MODE_CO2;
    else if (tz && cz) mode = MODE_HUM;
    else if (hz && cz) mode = MODE_TEMP;
    else if (cz)       mode = MODE_TEMP_HUM;
    else if (hz)       mode = MODE_TEMP_CO2;
    else if (tz)       mode = MODE_HUM_CO2;
    else               mode = MODE_ALL;
    mode_hits[mode]++;

    case (mode)
      MODE_CO2: fan_st = hyst(fan_st, c_high, c_ok);
      MODE_HUM: begin
        pump_st = hyst(pump_st, h_dry, h_wetok);
        fan_st  = hyst(fan_st, h_wet, h_dryok);
      end
      MODE_TEMP: begin
        pump_st  = hyst(pump_st, t_high, t_low);
        fan_st   = hyst(fan_st, t_far, t_near);
        valve_st = hyst(valve_st, t_high, t_low);
      end
      MODE_TEMP_HUM: begin
        pump_st  = hyst(pump_st, t_high || h_dry, t_low && h_wetok);
        fan_st   = hyst(fan_st, t_far || h_wet, t_near && h_dryok);
        valve_st = hyst(valve_st, t_high, t_low);
      end
      MODE_TEMP_CO2: begin
        pump_st  = hyst(pump_st, t_high, t_low);
        fan_st   = hyst(fan_st, t_far || c_high, t_near && c_ok);
        valve_st = hyst(valve_st, t_high, t_low);
      end
      MODE_HUM_CO2: begin
        pump_st = hyst(pump_st, h_dry, h_wetok);
        fan_st  = hyst(fan_st, h_wet || c_high, h_dryok && c_ok);
      end
      MODE_ALL: begin
        pump_st  = hyst(pump_st, t_high || h_dry, t_low && h_wetok);
        fan_st   = hyst(fan_st, t_far || h_wet || c_high, t_near && h_dryok && c_ok);
        valve_st = hyst(valve_st, t_high, t_low);
      end
      default: begin
        pump_st  = cfg_switches[0];
        fan_st   = cfg_switches[1];
        valve_st = cfg_switches[2];
      end
    endcase

    r.pump  = pump_st;
    r.fan   = fan_st;
    r.valve = valve_st;
    r.led   = cfg_switches[3];
    return r;
  endfunction

  // Sample source: holds an item until it is taken, may idle between items.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || offer_taken) begin
      if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, pending_samples[0]};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    offer_taken = 1'b0;
  end

  // Result sink: random stalls, plus a long hold-off on request.
  int hold_left = 0;
  int hold_granted = 0;
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_granted != hold_requests) begin
      hold_granted = hold_requests;
      hold_left = LONG_HOLD;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Accepted samples are predicted here, accepted results checked in order.
  string relay_names[4] = '{"pump_on", "fan_on", "valve_on", "led_on"};
  always @(posedge clk) begin : monitor_proc
    relay_out_t want;
    logic [3:0] want_bits;
    if (!rst && s_tvalid && s_tready) begin
      expected_relays.push_back(next_relays(pending_samples.pop_front()));
      offer_taken = 1'b1;
      samples_in++;
    end
    if (!rst && m_tvalid && m_tready) begin
      results_out++;
      if (expected_relays.size() == 0) begin
        $error("result %h arrived with no sample outstanding", m_tdata);
        errors++;
      end else begin
        want = expected_relays.pop_front();
        want_bits = want;
        for (int i = 0; i < 4; i++) begin
          if (m_tdata[i] !== want_bits[i]) begin
            $error("%s mismatch: expected %0b, got %0b", relay_names[i], want_bits[i],
                   m_tdata[i]);
            errors++;
          end
        end
      end
    end
  end

  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("No handshake for %0d cycles, %0d results still owed", STALL_LIMIT,
               expected_relays.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_AUTO_ENABLE: cfg_auto     = data[0];
      REG_TEMP_SP:     cfg_temp_sp  = data[6:0];
      REG_HUM_SP:      cfg_hum_sp   = data[6:0];
      REG_CO2_SP:      cfg_co2_sp   = data[15:0];
      REG_MANUAL:      cfg_switches = data[3:0];
      default: ;
    endcase
  endtask

  // Narrow registers get random upper bits, which the block must discard.
  // A write to an unused index follows, which must change nothing.
  task automatic set_config(bit auto_on, int temp_sp, int hum_sp, int co2_sp, int sw);
    logic [CfgDataW-1:0] junk;
    junk = CfgDataW'($urandom);
    write_cfg(REG_AUTO_ENABLE, {junk[15:1], auto_on});
    write_cfg(REG_TEMP_SP, {junk[15:7], 7'(temp_sp)});
    write_cfg(REG_HUM_SP, {junk[15:7], 7'(hum_sp)});
    write_cfg(REG_CO2_SP, 16'(co2_sp));
    write_cfg(REG_MANUAL, {junk[15:4], 4'(sw)});
    write_cfg(CfgIdxW'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)), CfgDataW'($urandom));
    settings_used++;
  endtask

  task automatic queue_sample(int co2, int temp, int hum);
    sample_t s;
    s.co2  = 16'(co2);
    s.temp = 11'(temp);
    s.hum  = 10'(hum);
    pending_samples.push_back(s);
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || expected_relays.size() != 0) @(posedge clk);
  endtask

  // Mostly values around the setpoint so the hysteresis edges are crossed often.
  function automatic int pick_field(int centre, int spread, int lo, int hi);
    case ($urandom_range(9))
      0:       return int'($urandom);
      1, 2:    return lo + int'($urandom_range(hi - lo));
      default: return centre - spread + int'($urandom_range(2 * spread));
    endcase
  endfunction

  function automatic int pick_setpoint(int top, int field_max);
    case ($urandom_range(9))
      0:       return top;
      1:       return field_max;
      default: return int'($urandom_range(top, 1));
    endcase
  endfunction

  initial begin
    logic [2:0] zeros;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, no idling. Reset values first: manual mode, switches off.
    queue_sample(0, -1024, 0);
    queue_sample(65535, 1023, 1023);
    wait_drained();
    set_config(0, 0, 0, 0, 15);
    queue_sample(1000, 200, 500);
    wait_drained();
    set_config(0, 0, 0, 0, 5);
    queue_sample(1000, 200, 500);
    wait_drained();
    // All setpoints zero falls back to CO2 control around zero.
    set_config(1, 0, 0, 0, 8);
    queue_sample(600, 0, 0);
    queue_sample(300, 0, 0);
    queue_sample(0, 0, 0);
    wait_drained();
    // Temperature only: on above the band, kept inside it, off at the setpoint.
    set_config(1, 25, 0, 0, 0);
    queue_sample(0, 281, 0);
    queue_sample(0, 260, 0);
    queue_sample(0, 252, 0);
    queue_sample(0, 250, 0);
    queue_sample(0, -1024, 0);
    wait_drained();
    set_config(1, 70, 100, 40000, 7);
    queue_sample(40501, 700, 0);
    queue_sample(40000, 700, 1000);
    queue_sample(0, 1023, 1000);
    wait_drained();
    // Setpoints beyond their stated range are used as they are.
    set_config(1, 127, 127, 65535, 15);
    queue_sample(65535, 1023, 1023);
    queue_sample(0, -1024, 0);
    wait_drained();

    // Random part: a fresh setting and idling pattern per phase.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      zeros = 3'($urandom);
      set_config($urandom_range(4) != 0,
                 zeros[0] ? 0 : pick_setpoint(70, 127),
                 zeros[1] ? 0 : pick_setpoint(100, 127),
                 zeros[2] ? 0 : pick_setpoint(40000, 65535),
                 $urandom_range(15));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      // Sink holds off while the source keeps offering, so the input stalls.
      if (ph == 4) hold_requests++;
      for (int i = 0; i < PHASE_ITEMS; i++)
        queue_sample(pick_field(int'(cfg_co2_sp), 700, 0, 40000),
                     pick_field(10 * int'(cfg_temp_sp), 45, -400, 700),
                     pick_field(10 * int'(cfg_hum_sp), 70, 0, 1000));
      wait_drained();
    end

    repeat (10) @(posedge clk);
    $display("Ran %0d samples and %0d results over %0d register settings.", samples_in,
             results_out, settings_used);
    $display("Control modes reached (CO2, hum, temp, T+H, T+C, H+C, all, manual): "
             , "%0d %0d %0d %0d %0d %0d %0d %0d", mode_hits[MODE_CO2], mode_hits[MODE_HUM],
             mode_hits[MODE_TEMP], mode_hits[MODE_TEMP_HUM], mode_hits[MODE_TEMP_CO2],
             mode_hits[MODE_HUM_CO2], mode_hits[MODE_ALL], mode_hits[MODE_MANUAL]);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/crhc_pkg.sv
rtl/crhc_band.sv
rtl/crhc_relay.sv
rtl/climate_relay_hysteresis_controller.sv
tb/tb_climate_relay_hysteresis_controller.sv
